/* src/fmst_pkg.sv */
// shared constants, register codes and sine table builder for the fm siren tone generator
package fmst_pkg;

   // defaults for the top-level parameters
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int MAX_BURST_DEF       = 64;

   // field widths
   localparam int SAMPLE_RATE_W  = 18;
   localparam int BASE_FREQ_W    = 15;
   localparam int MOD_DEPTH_W    = 10;
   localparam int MOD_STEPS_W    = 16;
   localparam int GAIN_W         = 9;
   localparam int SAMPLE_COUNT_W = 7;
   localparam int SAMPLE_W       = 16;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 18;

   // internal widths
   localparam int FREQ_W   = 16;   // base + offset, floored at one
   localparam int COUNT_W  = 16;   // phase count and wobble step
   localparam int OFFSET_W = 11;   // signed frequency offset
   localparam int MAG_W    = 15;   // sine magnitude

   // register index codes
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_RATE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_FREQ   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MOD_DEPTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MOD_STEPS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN        = 3'd4;

   // register reset values
   localparam logic [SAMPLE_RATE_W-1:0] SAMPLE_RATE_RST = 18'd44100;
   localparam logic [BASE_FREQ_W-1:0]   BASE_FREQ_RST   = 15'd440;
   localparam logic [MOD_DEPTH_W-1:0]   MOD_DEPTH_RST   = 10'd100;
   localparam logic [MOD_STEPS_W-1:0]   MOD_STEPS_RST   = 16'd1000;
   localparam logic [GAIN_W-1:0]        GAIN_RST        = 9'd179;

   // full scale of a sine entry, divisor of the wobble offset
   localparam logic [MAG_W-1:0] SINE_FULL_SCALE = 15'd32767;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // one quarter-wave entry, integer taylor series in q30, evaluated at elaboration
   function automatic logic [MAG_W-1:0] quarter_sine_entry(input int unsigned k,
                                                           input int unsigned qbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      int unsigned n;
      x    = (64'(k) * HALF_PI_Q30) >> qbits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (n = 1; n <= 8; n++) begin
         term = (term * x2) >> 30;
         case (n)
            1: term = term / 64'd6;
            2: term = term / 64'd20;
            3: term = term / 64'd42;
            4: term = term / 64'd72;
            5: term = term / 64'd110;
            6: term = term / 64'd156;
            7: term = term / 64'd210;
            default: term = term / 64'd272;
         endcase
         if (n[0]) begin
            sum = (sum > term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[MAG_W-1:0];
   endfunction

endpackage

/* src/fmst_sine_rom.sv */
// quarter-wave sine rom with registered magnitude and sign
module fmst_sine_rom #(
   parameter int TABLE_BITS = fmst_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic [TABLE_BITS-1:0]        phase,
   output logic [fmst_pkg::MAG_W-1:0]   mag,
   output logic                         neg
);

   localparam int QB   = TABLE_BITS - 2;
   localparam int QLEN = 1 << QB;

   logic [fmst_pkg::MAG_W-1:0] rom_w [QLEN+1];
   logic [1:0]                 quad;
   logic [QB-1:0]              idx;
   logic [QB:0]                addr;
   logic [fmst_pkg::MAG_W-1:0] mag_ff;
   logic                       neg_ff;

   for (genvar k = 0; k <= QLEN; k++) begin : g_rom
      localparam logic [fmst_pkg::MAG_W-1:0] ENTRY =
         fmst_pkg::quarter_sine_entry(k, QB);
      assign rom_w[k] = ENTRY;
   end

   assign quad = phase[TABLE_BITS-1:TABLE_BITS-2];
   assign idx  = phase[QB-1:0];
   // odd quadrants read the table backwards
   assign addr = quad[0] ? ((QB+1)'(QLEN) - {1'b0, idx}) : {1'b0, idx};

   always_ff @(posedge clock) begin
      mag_ff <= rom_w[addr];
      neg_ff <= quad[1];
   end

   assign mag = mag_ff;
   assign neg = neg_ff;

endmodule

/* src/fmst_serial_div.sv */
// restoring divider, one quotient bit per cycle
module fmst_serial_div #(
   parameter int NUM_W = 43,
   parameter int DEN_W = fmst_pkg::SAMPLE_RATE_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   assign trial = {rem_ff, q_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         q_in   = {q_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

/* src/fmst_serial_mul.sv */
// shift-add multiplier, one multiplier bit per cycle
module fmst_serial_mul #(
   parameter int A_W = fmst_pkg::FREQ_W,
   parameter int B_W = fmst_pkg::COUNT_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [A_W-1:0]       a,
   input  logic [B_W-1:0]       b,
   output logic                 done,
   output logic [A_W+B_W-1:0]   prod
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [A_W+B_W-1:0] p_ff, p_in;
   logic [A_W-1:0]     a_ff, a_in;
   logic [A_W:0]       sum;

   assign sum = {1'b0, p_ff[A_W+B_W-1:B_W]} + (p_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      p_in    = p_ff;
      a_in    = a_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(B_W);
         p_in    = {{A_W{1'b0}}, b};
         a_in    = a;
      end else if (busy_ff) begin
         p_in   = {sum, p_ff[B_W-1:1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      a_ff <= a_in;
   end

   assign done = done_ff;
   assign prod = p_ff;

endmodule

/* src/fm_siren_tone_generator_top.sv */
// top level of the fm siren tone generator: sequencer, state and registers
//
// channel | direction | transfer                        | payload
// req     | in        | req_valid & req_ready           | req_sample_count (burst length)
// rsp     | out       | rsp_valid & rsp_ready           | rsp_sample (q1.15), rsp_last
// csr     | in        | csr_valid & csr_ready (always 1)| csr_index, csr_data
//
// each sample runs a bit-serial divide for the period, a 16-step multiply and a
// bit-serial divide for the tone phase, then a 16-step gain multiply
// a period restart adds two more divides and a multiply
// the divider width (33+SINE_TABLE_BITS bits, one bit a cycle) sets the pace
// req is taken only between bursts; a full output register holds the sequencer
// in its emit step until the pending transfer goes out
// reset is synchronous and restores the register defaults and clears the tone state
module fm_siren_tone_generator_top #(
   parameter int SINE_TABLE_BITS = fmst_pkg::SINE_TABLE_BITS_DEF,
   parameter int MAX_BURST       = fmst_pkg::MAX_BURST_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // burst requests
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [fmst_pkg::SAMPLE_COUNT_W-1:0]  req_sample_count,
   // samples
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [fmst_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                 rsp_last,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fmst_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fmst_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int B        = SINE_TABLE_BITS;
   localparam int LEFT_W   = $clog2(MAX_BURST + 1);
   localparam int FREQ_W   = fmst_pkg::FREQ_W;
   localparam int COUNT_W  = fmst_pkg::COUNT_W;
   localparam int OFFSET_W = fmst_pkg::OFFSET_W;
   localparam int MAG_W    = fmst_pkg::MAG_W;
   localparam int DEN_W    = fmst_pkg::SAMPLE_RATE_W;
   // tone numerator: freq * count (32 bits) scaled by the table size, plus rounding
   localparam int NUM_W    = FREQ_W + COUNT_W + B + 1;
   localparam int PROD_W   = FREQ_W + COUNT_W;

   // sequencer states
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_PER_GO   = 4'd1;
   localparam logic [3:0] ST_PER_RUN  = 4'd2;
   localparam logic [3:0] ST_WPH_RUN  = 4'd3;
   localparam logic [3:0] ST_WSIN     = 4'd4;
   localparam logic [3:0] ST_WMUL_RUN = 4'd5;
   localparam logic [3:0] ST_WDIV_RUN = 4'd6;
   localparam logic [3:0] ST_TMUL_GO  = 4'd7;
   localparam logic [3:0] ST_TMUL_RUN = 4'd8;
   localparam logic [3:0] ST_TDIV_RUN = 4'd9;
   localparam logic [3:0] ST_TSIN     = 4'd10;
   localparam logic [3:0] ST_GMUL_RUN = 4'd11;
   localparam logic [3:0] ST_EMIT     = 4'd12;

   // configuration registers
   logic [fmst_pkg::SAMPLE_RATE_W-1:0] sample_rate_ff, sample_rate_in;
   logic [fmst_pkg::BASE_FREQ_W-1:0]   base_freq_ff, base_freq_in;
   logic [fmst_pkg::MOD_DEPTH_W-1:0]   mod_depth_ff, mod_depth_in;
   logic [fmst_pkg::MOD_STEPS_W-1:0]   mod_steps_ff, mod_steps_in;
   logic [fmst_pkg::GAIN_W-1:0]        gain_ff, gain_in;

   // sequencer and tone state
   logic [3:0]                 state_ff, state_in;
   logic [LEFT_W-1:0]          left_ff, left_in;
   logic [COUNT_W-1:0]         phase_count_ff, phase_count_in;
   logic [COUNT_W-1:0]         wobble_step_ff, wobble_step_in;
   logic signed [OFFSET_W-1:0] freq_offset_ff, freq_offset_in;
   logic                       sign_ff, sign_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [fmst_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_last_ff, rsp_last_in;

   // arithmetic units
   logic               div_start;
   logic [NUM_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;
   logic               div_done;
   logic [NUM_W-1:0]   div_quot;
   logic               mul_start;
   logic [FREQ_W-1:0]  mul_a;
   logic [COUNT_W-1:0] mul_b;
   logic               mul_done;
   logic [PROD_W-1:0]  mul_prod;
   logic [MAG_W-1:0]   rom_mag;
   logic               rom_neg;

   // derived values
   logic signed [FREQ_W:0]        freq_sum;
   logic [FREQ_W-1:0]             freq;
   logic [COUNT_W-1:0]            steps_eff;
   logic [COUNT_W:0]              step_next;
   logic                          period_hit;
   logic [9:0]                    om_mag;
   logic [OFFSET_W-1:0]           offset_new;
   logic [MAG_W+1:0]              gained;
   logic [fmst_pkg::SAMPLE_W-1:0] sample_val;
   logic [LEFT_W-1:0]             burst_len;
   logic                          out_free;

   fmst_serial_div #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (div_den),
      .done (div_done),
      .quot (div_quot)
   );

   fmst_serial_mul #(
      .A_W(FREQ_W),
      .B_W(COUNT_W)
   ) u_mul (
      .clock(clock),
      .reset(reset),
      .start(mul_start),
      .a    (mul_a),
      .b    (mul_b),
      .done (mul_done),
      .prod (mul_prod)
   );

   // the rom always looks at the divider quotient: wobble phase or tone phase
   fmst_sine_rom #(
      .TABLE_BITS(B)
   ) u_rom (
      .clock(clock),
      .phase(div_quot[B-1:0]),
      .mag  (rom_mag),
      .neg  (rom_neg)
   );

   // current frequency, floored at one
   assign freq_sum = $signed({2'b00, base_freq_ff}) + (FREQ_W+1)'(freq_offset_ff);
   assign freq     = (freq_sum < $signed((FREQ_W+1)'(1))) ? FREQ_W'(1) : freq_sum[FREQ_W-1:0];

   // zero wobble length behaves as one
   assign steps_eff = (mod_steps_ff == '0) ? COUNT_W'(1) : mod_steps_ff;
   assign step_next = {1'b0, wobble_step_ff} + (COUNT_W+1)'(1);

   assign period_hit = {2'b00, phase_count_ff} >= div_quot[DEN_W-1:0];

   // wobble offset magnitude is at most the depth, ten bits
   assign om_mag     = div_quot[9:0];
   assign offset_new = sign_ff ? (OFFSET_W'(0) - {1'b0, om_mag}) : {1'b0, om_mag};

   // gain stage: magnitude * gain >> 8, then saturate to q1.15
   assign gained = mul_prod[8 +: MAG_W+2];

   always_comb begin
      if (sign_ff) begin
         sample_val = (gained > (MAG_W+2)'(32768)) ? 16'h8000
                                                   : 16'((MAG_W+2)'(0) - gained);
      end else begin
         sample_val = (gained > (MAG_W+2)'(32767)) ? 16'h7fff : gained[15:0];
      end
   end

   // bursts longer than the limit are cut to it
   assign burst_len = (req_sample_count > fmst_pkg::SAMPLE_COUNT_W'(MAX_BURST))
                      ? LEFT_W'(MAX_BURST) : LEFT_W'(req_sample_count);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;

   // register file
   always_comb begin
      sample_rate_in = sample_rate_ff;
      base_freq_in   = base_freq_ff;
      mod_depth_in   = mod_depth_ff;
      mod_steps_in   = mod_steps_ff;
      gain_in        = gain_ff;
      if (csr_valid) begin
         case (csr_index)
            fmst_pkg::REG_SAMPLE_RATE: sample_rate_in = csr_data;
            fmst_pkg::REG_BASE_FREQ:   base_freq_in   = csr_data[fmst_pkg::BASE_FREQ_W-1:0];
            fmst_pkg::REG_MOD_DEPTH:   mod_depth_in   = csr_data[fmst_pkg::MOD_DEPTH_W-1:0];
            fmst_pkg::REG_MOD_STEPS:   mod_steps_in   = csr_data[fmst_pkg::MOD_STEPS_W-1:0];
            fmst_pkg::REG_GAIN:        gain_in        = csr_data[fmst_pkg::GAIN_W-1:0];
            default: ;   // unknown index, write dropped
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      left_in        = left_ff;
      phase_count_in = phase_count_ff;
      wobble_step_in = wobble_step_ff;
      freq_offset_in = freq_offset_ff;
      sign_in        = sign_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_sample_in  = rsp_sample_ff;
      rsp_last_in    = rsp_last_ff;
      div_start      = 1'b0;
      div_num        = '0;
      div_den        = '0;
      mul_start      = 1'b0;
      mul_a          = '0;
      mul_b          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && burst_len != '0) begin
               left_in  = burst_len;
               state_in = ST_PER_GO;
            end
         end
         ST_PER_GO: begin
            // period = sample_rate / freq
            div_start = 1'b1;
            div_num   = NUM_W'(sample_rate_ff);
            div_den   = DEN_W'(freq);
            state_in  = ST_PER_RUN;
         end
         ST_PER_RUN: begin
            if (div_done) begin
               if (period_hit) begin
                  // wobble phase = round(step * 2^b / steps)
                  div_start = 1'b1;
                  div_num   = NUM_W'({wobble_step_ff, {B{1'b0}}})
                              + NUM_W'(steps_eff[COUNT_W-1:1]);
                  div_den   = DEN_W'(steps_eff);
                  state_in  = ST_WPH_RUN;
               end else begin
                  state_in = ST_TMUL_GO;
               end
            end
         end
         ST_WPH_RUN: begin
            if (div_done) begin
               state_in = ST_WSIN;
            end
         end
         ST_WSIN: begin
            sign_in   = rom_neg;
            mul_start = 1'b1;
            mul_a     = FREQ_W'(rom_mag);
            mul_b     = COUNT_W'(mod_depth_ff);
            state_in  = ST_WMUL_RUN;
         end
         ST_WMUL_RUN: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_num   = NUM_W'(mul_prod);
               div_den   = DEN_W'(fmst_pkg::SINE_FULL_SCALE);
               state_in  = ST_WDIV_RUN;
            end
         end
         ST_WDIV_RUN: begin
            if (div_done) begin
               freq_offset_in = $signed(offset_new);
               phase_count_in = '0;
               wobble_step_in = (step_next >= {1'b0, steps_eff}) ? '0
                                : step_next[COUNT_W-1:0];
               state_in       = ST_TMUL_GO;
            end
         end
         ST_TMUL_GO: begin
            mul_start = 1'b1;
            mul_a     = freq;
            mul_b     = phase_count_ff;
            state_in  = ST_TMUL_RUN;
         end
         ST_TMUL_RUN: begin
            if (mul_done) begin
               // tone phase = round(freq * count * 2^b / sample_rate); zero rate gives 0/1
               div_start = 1'b1;
               if (sample_rate_ff != '0) begin
                  div_num = NUM_W'({mul_prod, {B{1'b0}}})
                            + NUM_W'(sample_rate_ff[DEN_W-1:1]);
                  div_den = sample_rate_ff;
               end else begin
                  div_num = '0;
                  div_den = DEN_W'(1);
               end
               state_in = ST_TDIV_RUN;
            end
         end
         ST_TDIV_RUN: begin
            if (div_done) begin
               state_in = ST_TSIN;
            end
         end
         ST_TSIN: begin
            sign_in   = rom_neg;
            mul_start = 1'b1;
            mul_a     = FREQ_W'(rom_mag);
            mul_b     = COUNT_W'(gain_ff);
            state_in  = ST_GMUL_RUN;
         end
         ST_GMUL_RUN: begin
            if (mul_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_sample_in  = sample_val;
               rsp_last_in    = left_ff == LEFT_W'(1);
               phase_count_in = phase_count_ff + COUNT_W'(1);
               left_in        = left_ff - LEFT_W'(1);
               state_in       = (left_ff == LEFT_W'(1)) ? ST_IDLE : ST_PER_GO;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= fmst_pkg::SAMPLE_RATE_RST;
         base_freq_ff   <= fmst_pkg::BASE_FREQ_RST;
         mod_depth_ff   <= fmst_pkg::MOD_DEPTH_RST;
         mod_steps_ff   <= fmst_pkg::MOD_STEPS_RST;
         gain_ff        <= fmst_pkg::GAIN_RST;
         state_ff       <= ST_IDLE;
         left_ff        <= '0;
         phase_count_ff <= '0;
         wobble_step_ff <= '0;
         freq_offset_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         sample_rate_ff <= sample_rate_in;
         base_freq_ff   <= base_freq_in;
         mod_depth_ff   <= mod_depth_in;
         mod_steps_ff   <= mod_steps_in;
         gain_ff        <= gain_in;
         state_ff       <= state_in;
         left_ff        <= left_in;
         phase_count_ff <= phase_count_in;
         wobble_step_ff <= wobble_step_in;
         freq_offset_ff <= freq_offset_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff       <= sign_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = $signed(rsp_sample_ff);
   assign rsp_last   = rsp_last_ff;

endmodule
